### src/tmpm_pkg.sv
// Shared types and constants for the trie multi-pattern matcher.
`default_nettype none
package tmpm_pkg;

   localparam int TRIE_NODES      = 1024;
   localparam int MAX_PATTERN_LEN = 16;
   localparam int ALPHABET        = 4;
   localparam int NODE_W          = $clog2(TRIE_NODES);
   localparam int COUNT_W         = NODE_W + 1;
   localparam int DEPTH_W         = $clog2(MAX_PATTERN_LEN + 1);
   localparam int WIN_IDX_W       = (MAX_PATTERN_LEN > 1) ? $clog2(MAX_PATTERN_LEN) : 1;
   localparam int POS_W           = 24;
   localparam int SYM_W           = 2;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] CMD_PATTERN = 2'd0;
   localparam logic [1:0] CMD_TEXT    = 2'd1;
   localparam logic [1:0] CMD_CLEAR   = 2'd2;

   typedef enum logic [1:0] {
      OP_PATTERN,
      OP_TEXT,
      OP_CLEAR
   } op_type;

   typedef struct packed {
      logic [1:0]       command;
      logic [SYM_W-1:0] symbol;
      logic             final_symbol;
   } req_type;

   typedef struct packed {
      logic [POS_W-1:0] position;
      logic             matched;
      logic             run_last;
      logic             overflow;
   } rsp_type;

   typedef struct packed {
      op_type           op;
      logic [SYM_W-1:0] symbol;
      logic             fin;
   } job_type;

   typedef struct packed {
      logic                             end_mark;
      logic [ALPHABET-1:0][NODE_W-1:0]  child;
   } row_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_PCHK,
      S_PZERO,
      S_PFIN,
      S_PMARK,
      S_TSEL,
      S_WCHK,
      S_ADV,
      S_CLOSE
   } state_type;

endpackage
`default_nettype wire

### src/trie_multi_pattern_matcher.sv
// Top level of the trie multi-pattern matcher.
`default_nettype none
// Pattern beats build a trie in a node memory (one row per node: four child
// pointers and an end mark); text beats slide a window of the newest symbols
// and settle start positions by walking the trie from the root. A front queue of
// four beats decouples input from the engine. A pattern symbol passes S_PCHK unless
// dropped, S_PZERO for a fresh row, S_PFIN, and S_PMARK if it ends a kept pattern;
// a clear passes S_INIT; a text symbol shifts into the window. Each start position
// it settles passes S_TSEL, S_WCHK per row read, and S_ADV, which on a match waits
// for a free result register. Rows are tracked by a fill count, so neither reset
// nor clear needs a memory sweep. Match beats come out in increasing position
// order; the final text symbol ends with a closing beat carrying run_last.
module trie_multi_pattern_matcher
   import tmpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   logic    job_valid;
   job_type job_data;
   logic    job_pop;

   tmpm_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop)
   );

   tmpm_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job_data  (job_data),
      .job_pop   (job_pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
`default_nettype wire

### src/tmpm_front.sv
// Front end: accepts request beats, classifies them and queues jobs for the engine.
`default_nettype none
module tmpm_front
   import tmpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req_data,
   output logic         job_valid,
   output job_type      job_data,
   input  wire logic    job_pop
);

   job_type               queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]       count_ff, count_in;
   logic                  push;
   logic                  take;
   job_type               job_new;

   assign req_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign take      = req_valid && req_ready;

   always_comb begin
      job_new.symbol = req_data.symbol;
      job_new.fin    = req_data.final_symbol;
      push           = take;
      case (req_data.command)
         CMD_PATTERN: job_new.op = OP_PATTERN;
         CMD_TEXT:    job_new.op = OP_TEXT;
         CMD_CLEAR:   job_new.op = OP_CLEAR;
         default: begin
            // unused command: accept the beat and drop it
            job_new.op = OP_CLEAR;
            push       = 1'b0;
         end
      endcase
   end

   assign job_valid = (count_ff != '0);
   assign job_data  = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = job_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !job_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && job_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= job_new;
      end
   end

endmodule
`default_nettype wire

### src/tmpm_back.sv
// Back end: trie node memory, pattern insertion, text window and match walks.
`default_nettype none
module tmpm_back
   import tmpm_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    job_valid,
   input  wire job_type job_data,
   output logic         job_pop,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp_data
);

   // node memory
   row_type             mem [TRIE_NODES];
   row_type             rd_ff;
   logic                mem_we;
   logic [NODE_W-1:0]   mem_wa;
   row_type             mem_wd;
   logic [NODE_W-1:0]   mem_ra;

   state_type           state_ff, state_in;

   logic [COUNT_W-1:0]  node_count_ff, node_count_in;
   logic [NODE_W-1:0]   insert_node_ff, insert_node_in;
   logic [DEPTH_W-1:0]  insert_depth_ff, insert_depth_in;
   logic                dropped_ff, dropped_in;
   logic                overflow_ff, overflow_in;
   logic [NODE_W-1:0]   new_node_ff, new_node_in;

   logic [SYM_W-1:0]    window_ff [MAX_PATTERN_LEN];
   logic [SYM_W-1:0]    window_in [MAX_PATTERN_LEN];
   logic [POS_W-1:0]    text_count_ff, text_count_in;
   logic [POS_W-1:0]    next_start_ff, next_start_in;
   logic [DEPTH_W-1:0]  pend_ff, pend_in;

   logic [SYM_W-1:0]    sym_ff, sym_in;
   logic                fin_ff, fin_in;
   logic [NODE_W-1:0]   walk_node_ff, walk_node_in;
   logic [DEPTH_W-1:0]  walk_i_ff, walk_i_in;
   logic                match_ff, match_in;

   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;
   logic                out_free;

   logic [DEPTH_W-1:0]  win_sum;
   logic [SYM_W-1:0]    walk_sym;
   logic [NODE_W-1:0]   walk_child;
   logic                walk_match;
   logic                walk_len_out;
   logic                walk_pending;
   logic                walk_miss;
   logic                walk_step;
   logic [NODE_W-1:0]   pat_child;
   logic                trie_full;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // walk decision on the row just read
   assign win_sum      = DEPTH_W'(MAX_PATTERN_LEN) - pend_ff + walk_i_ff;
   assign walk_sym     = window_ff[win_sum[WIN_IDX_W-1:0]];
   assign walk_child   = rd_ff.child[walk_sym];
   assign walk_match   = rd_ff.end_mark;
   assign walk_len_out = (walk_i_ff >= DEPTH_W'(MAX_PATTERN_LEN));
   assign walk_pending = (walk_i_ff >= pend_ff);
   assign walk_miss    = !walk_match &&
                         (walk_len_out || (!walk_pending && (walk_child == '0)));
   assign walk_step    = !walk_match && !walk_len_out && !walk_pending &&
                         (walk_child != '0);

   assign pat_child = rd_ff.child[sym_ff];
   assign trie_full = (node_count_ff >= COUNT_W'(TRIE_NODES));

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_INIT: state_in = S_IDLE;
         S_IDLE: begin
            if (job_valid) begin
               case (job_data.op)
                  OP_PATTERN: begin
                     if (dropped_ff || (insert_depth_ff >= DEPTH_W'(MAX_PATTERN_LEN))) begin
                        state_in = S_PFIN;
                     end else begin
                        state_in = S_PCHK;
                     end
                  end
                  OP_TEXT:  state_in = S_TSEL;
                  OP_CLEAR: state_in = S_INIT;
                  default:  state_in = S_IDLE;
               endcase
            end
         end
         S_PCHK: begin
            if (pat_child == '0 && !trie_full) begin
               state_in = S_PZERO;
            end else begin
               state_in = S_PFIN;
            end
         end
         S_PZERO: state_in = S_PFIN;
         S_PFIN: begin
            if (fin_ff && !dropped_ff && insert_node_ff != '0) begin
               state_in = S_PMARK;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_PMARK: state_in = S_IDLE;
         S_TSEL: begin
            if (pend_ff != '0) begin
               state_in = S_WCHK;
            end else if (fin_ff) begin
               state_in = S_CLOSE;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_WCHK: begin
            if (walk_match || walk_miss) begin
               state_in = S_ADV;
            end else if (walk_pending) begin
               state_in = fin_ff ? S_ADV : S_IDLE;
            end else begin
               state_in = S_WCHK;
            end
         end
         S_ADV: begin
            if (!match_ff || out_free) begin
               state_in = S_TSEL;
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      mem_we          = 1'b0;
      mem_wa          = '0;
      mem_wd          = '0;
      mem_ra          = '0;
      job_pop         = 1'b0;
      node_count_in   = node_count_ff;
      insert_node_in  = insert_node_ff;
      insert_depth_in = insert_depth_ff;
      dropped_in      = dropped_ff;
      overflow_in     = overflow_ff;
      new_node_in     = new_node_ff;
      window_in       = window_ff;
      text_count_in   = text_count_ff;
      next_start_in   = next_start_ff;
      pend_in         = pend_ff;
      sym_in          = sym_ff;
      fin_in          = fin_ff;
      walk_node_in    = walk_node_ff;
      walk_i_in       = walk_i_ff;
      match_in        = match_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_data_in     = rsp_data_ff;

      case (state_ff)
         S_INIT: begin
            // root row is the only live row after reset or clear
            mem_we = 1'b1;
            mem_wa = '0;
            mem_wd = '0;
         end
         S_IDLE: begin
            if (job_valid) begin
               job_pop = 1'b1;
               sym_in  = job_data.symbol;
               fin_in  = job_data.fin;
               case (job_data.op)
                  OP_PATTERN: begin
                     mem_ra = insert_node_ff;
                     if (!dropped_ff && (insert_depth_ff >= DEPTH_W'(MAX_PATTERN_LEN))) begin
                        overflow_in = 1'b1;
                        dropped_in  = 1'b1;
                     end
                  end
                  OP_TEXT: begin
                     for (int k = 0; k < MAX_PATTERN_LEN - 1; k++) begin
                        window_in[k] = window_ff[k+1];
                     end
                     window_in[MAX_PATTERN_LEN-1] = job_data.symbol;
                     text_count_in = text_count_ff + 1'b1;
                     pend_in       = pend_ff + 1'b1;
                  end
                  OP_CLEAR: begin
                     node_count_in   = COUNT_W'(1);
                     insert_node_in  = '0;
                     insert_depth_in = '0;
                     dropped_in      = 1'b0;
                  end
                  default: ;
               endcase
            end
         end
         S_PCHK: begin
            if (pat_child != '0) begin
               insert_node_in  = pat_child;
               insert_depth_in = insert_depth_ff + 1'b1;
            end else if (trie_full) begin
               overflow_in = 1'b1;
               dropped_in  = 1'b1;
            end else begin
               mem_we                = 1'b1;
               mem_wa                = insert_node_ff;
               mem_wd                = rd_ff;
               mem_wd.child[sym_ff]  = node_count_ff[NODE_W-1:0];
               new_node_in           = node_count_ff[NODE_W-1:0];
               node_count_in         = node_count_ff + 1'b1;
               insert_node_in        = node_count_ff[NODE_W-1:0];
               insert_depth_in       = insert_depth_ff + 1'b1;
            end
         end
         S_PZERO: begin
            // wipe whatever a cleared trie left in the fresh row
            mem_we = 1'b1;
            mem_wa = new_node_ff;
            mem_wd = '0;
         end
         S_PFIN: begin
            mem_ra = insert_node_ff;
            if (fin_ff && !(!dropped_ff && insert_node_ff != '0)) begin
               insert_node_in  = '0;
               insert_depth_in = '0;
               dropped_in      = 1'b0;
            end
         end
         S_PMARK: begin
            mem_we          = 1'b1;
            mem_wa          = insert_node_ff;
            mem_wd          = rd_ff;
            mem_wd.end_mark = 1'b1;
            insert_node_in  = '0;
            insert_depth_in = '0;
            dropped_in      = 1'b0;
         end
         S_TSEL: begin
            mem_ra       = '0;
            walk_node_in = '0;
            walk_i_in    = '0;
         end
         S_WCHK: begin
            mem_ra   = walk_child;
            match_in = walk_match;
            if (walk_step) begin
               walk_node_in = walk_child;
               walk_i_in    = walk_i_ff + 1'b1;
            end
         end
         S_ADV: begin
            if (!match_ff || out_free) begin
               if (match_ff) begin
                  rsp_valid_in         = 1'b1;
                  rsp_data_in.position = next_start_ff;
                  rsp_data_in.matched  = 1'b1;
                  rsp_data_in.run_last = 1'b0;
                  rsp_data_in.overflow = overflow_ff;
               end
               next_start_in = next_start_ff + 1'b1;
               pend_in       = pend_ff - 1'b1;
            end
         end
         S_CLOSE: begin
            if (out_free) begin
               rsp_valid_in         = 1'b1;
               rsp_data_in.position = '0;
               rsp_data_in.matched  = 1'b0;
               rsp_data_in.run_last = 1'b1;
               rsp_data_in.overflow = overflow_ff;
               for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
                  window_in[k] = '0;
               end
               text_count_in = '0;
               next_start_in = '0;
               pend_in       = '0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      rd_ff <= mem[mem_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_INIT;
         node_count_ff   <= COUNT_W'(1);
         insert_node_ff  <= '0;
         insert_depth_ff <= '0;
         dropped_ff      <= 1'b0;
         overflow_ff     <= 1'b0;
         text_count_ff   <= '0;
         next_start_ff   <= '0;
         pend_ff         <= '0;
         rsp_valid_ff    <= 1'b0;
         for (int k = 0; k < MAX_PATTERN_LEN; k++) begin
            window_ff[k] <= '0;
         end
      end else begin
         state_ff        <= state_in;
         node_count_ff   <= node_count_in;
         insert_node_ff  <= insert_node_in;
         insert_depth_ff <= insert_depth_in;
         dropped_ff      <= dropped_in;
         overflow_ff     <= overflow_in;
         text_count_ff   <= text_count_in;
         next_start_ff   <= next_start_in;
         pend_ff         <= pend_in;
         rsp_valid_ff    <= rsp_valid_in;
         window_ff       <= window_in;
      end
   end

   always_ff @(posedge clock) begin
      new_node_ff  <= new_node_in;
      sym_ff       <= sym_in;
      fin_ff       <= fin_in;
      walk_node_ff <= walk_node_in;
      walk_i_ff    <= walk_i_in;
      match_ff     <= match_in;
      rsp_data_ff  <= rsp_data_in;
   end

endmodule
`default_nettype wire

### tb/sv/tb_top.sv
// Testbench for the trie multi-pattern matcher: random-stall stimulus and an in-order scoreboard.
`default_nettype none
module tb_top;
   import tmpm_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;

   // Trie and text-window predictor with a queue of expected match beats.
   class match_scoreboard;
      logic [NODE_W-1:0] kids[TRIE_NODES][ALPHABET];
      bit                marked[TRIE_NODES];
      int unsigned       nodes_used;
      int unsigned       cur_node;
      int unsigned       cur_depth;
      bit                dropping;
      logic [1:0]        window[MAX_PATTERN_LEN];
      logic [POS_W-1:0]  seen_count;
      logic [POS_W-1:0]  undecided;
      bit                ovf;
      rsp_type           pending[$];
      int                errors;
      int                match_count;
      int                closes;

      function void wipe_trie();
         foreach (kids[n, a]) kids[n][a] = '0;
         foreach (marked[n]) marked[n] = 0;
         nodes_used = 1;
         cur_node = 0;
         cur_depth = 0;
         dropping = 0;
      endfunction

      function void wipe_text();
         foreach (window[i]) window[i] = '0;
         seen_count = '0;
         undecided = '0;
      endfunction

      function void init();
         wipe_trie();
         wipe_text();
         ovf = 0;
         errors = 0;
         match_count = 0;
         closes = 0;
      endfunction

      // 0 pending, 1 match, 2 miss
      function int follow(int unsigned avail);
         int unsigned node;
         int unsigned child;
         node = 0;
         for (int unsigned i = 0; ; i++) begin
            if (marked[node]) return 1;
            if (i >= MAX_PATTERN_LEN) return 2;
            if (i >= avail) return 0;
            child = 32'(kids[node][window[MAX_PATTERN_LEN - (avail - i)]]);
            if (child == 0) return 2;
            node = child;
         end
      endfunction

      function void add_beat(logic [POS_W-1:0] pos, bit m, bit last);
         rsp_type r;
         r.position = pos;
         r.matched = m;
         r.run_last = last;
         r.overflow = ovf;
         pending = {pending, r};
      endfunction

      function void note_request(req_type q);
         int unsigned c;
         int unsigned avail;
         int          verdict;
         int          emitted;
         case (q.command)
            CMD_PATTERN: begin
               if (!dropping) begin
                  if (cur_depth >= MAX_PATTERN_LEN) begin
                     ovf = 1;
                     dropping = 1;
                  end else begin
                     c = 32'(kids[cur_node][q.symbol]);
                     if (c == 0) begin
                        if (nodes_used >= TRIE_NODES) begin
                           ovf = 1;
                           dropping = 1;
                        end else begin
                           c = nodes_used++;
                           kids[cur_node][q.symbol] = NODE_W'(c);
                        end
                     end
                     if (!dropping) begin
                        cur_node = c;
                        cur_depth++;
                     end
                  end
               end
               if (q.final_symbol) begin
                  if (!dropping && cur_node != 0) marked[cur_node] = 1;
                  cur_node = 0;
                  cur_depth = 0;
                  dropping = 0;
               end
            end
            CMD_TEXT: begin
               emitted = 0;
               for (int i = 0; i < MAX_PATTERN_LEN - 1; i++) window[i] = window[i+1];
               window[MAX_PATTERN_LEN-1] = q.symbol;
               seen_count = seen_count + 1'b1;
               while (undecided != seen_count) begin
                  avail = 32'(POS_W'(seen_count - undecided));
                  verdict = (avail > MAX_PATTERN_LEN) ? 2 : follow(avail);
                  if (verdict == 0) begin
                     if (!q.final_symbol) break;
                     verdict = 2;
                  end
                  if (verdict == 1 && emitted < MAX_PATTERN_LEN) begin
                     add_beat(undecided, 1, 0);
                     emitted++;
                  end
                  undecided = undecided + 1'b1;
               end
               if (q.final_symbol) begin
                  add_beat('0, 0, 1);
                  wipe_text();
               end
            end
            CMD_CLEAR: wipe_trie();
            default: ;
         endcase
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         if (pending.size() == 0) begin
            $display("%0t: unexpected beat %h", $time, got);
            errors++;
            return;
         end
         want = pending.pop_front();
         if (got.run_last) closes++; else match_count++;
         if (got.position !== want.position) begin
            $display("%0t: position expected %0d actual %0d", $time, want.position,
                     got.position);
            errors++;
         end
         if (got.matched !== want.matched) begin
            $display("%0t: matched expected %b actual %b", $time, want.matched, got.matched);
            errors++;
         end
         if (got.run_last !== want.run_last) begin
            $display("%0t: run_last expected %b actual %b", $time, want.run_last,
                     got.run_last);
            errors++;
         end
         if (got.overflow !== want.overflow) begin
            $display("%0t: overflow expected %b actual %b", $time, want.overflow,
                     got.overflow);
            errors++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   match_scoreboard board;
   int  idle_cycles;
   bit  hold_rsp;
   bit  long_hold_done;
   bit  stim_done;
   int  sent;
   logic [1:0] motif[4][$];

   trie_multi_pattern_matcher dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic void g_fill(ref logic [1:0] q[$], input int len);
      for (int i = 0; i < len; i++) q = {q, 2'($urandom_range(0, 3))};
   endfunction

   // Offer one beat at the falling edge and hold it until accepted.
   task automatic send(logic [1:0] cmd, logic [1:0] sym, bit fin);
      int g;
      g = (sent > 60 && sent < 380) ? gap_len() : 0;
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{command: cmd, symbol: sym, final_symbol: fin};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      board.note_request(req_data);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_pattern(logic [1:0] p[$]);
      foreach (p[i]) send(CMD_PATTERN, p[i], i == p.size() - 1);
   endtask

   task automatic wait_drain();
      req_valid <= 1'b0;
      while (board.pending.size() != 0) @(negedge clock);
      repeat (40) @(negedge clock);
   endtask

   // Receiver: random stalls, with one long hold-off requested by the sender side.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) board.check_result(rsp_data);
   end

   initial begin
      int g;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_ready <= 1'b0;
            repeat (300) @(negedge clock);
            hold_rsp = 0;
         end
         g = gap_len();
         if (g == 0) rsp_ready <= 1'b1;
         else begin
            rsp_ready <= 1'b0;
            repeat (g - 1) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      logic [1:0] p[$];
      int n;
      board = new();
      board.init();
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      hold_rsp = 0;
      long_hold_done = 0;
      stim_done = 0;
      sent = 0;
      idle_cycles = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: four patterns, nested patterns, too long, command 3, clear.
      p = '{0, 1};          send_pattern(p);
      p = '{0};             send_pattern(p);
      p = '{3, 3, 2};       send_pattern(p);
      p = '{2, 1, 0, 3};    send_pattern(p);
      send(CMD_UNUSED, 2'd1, 1'b1);
      send(CMD_TEXT, 0, 0); send(CMD_TEXT, 1, 0); send(CMD_TEXT, 3, 0);
      send(CMD_TEXT, 3, 0); send(CMD_TEXT, 2, 0); send(CMD_TEXT, 1, 0);
      send(CMD_TEXT, 0, 1);
      for (int i = 0; i < 17; i++) send(CMD_PATTERN, 3, i == 16);
      send(CMD_TEXT, 3, 1);
      send(CMD_CLEAR, 2, 1);
      send(CMD_TEXT, 0, 1);
      wait_drain();

      // Random: short patterns, then texts rich in those motifs.
      while (sent < 470) begin
         if ($urandom_range(0, 5) == 0) begin
            send(CMD_CLEAR, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         end
         n = $urandom_range(1, 4);
         for (int k = 0; k < n; k++) begin
            motif[k].delete();
            g_fill(motif[k], $urandom_range(1, 4));
            send_pattern(motif[k]);
         end
         if ($urandom_range(0, 9) == 0) send(CMD_PATTERN, 2'($urandom_range(0, 3)), 0);
         if ($urandom_range(0, 12) == 0) begin
            send(CMD_UNUSED, 2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
         end
         if (sent > 200 && !long_hold_done) begin
            hold_rsp = 1;
            long_hold_done = 1;
         end
         for (int t = 0; t < $urandom_range(3, 8); t++) begin
            if ($urandom_range(0, 2) == 0) begin
               p = motif[$urandom_range(0, n - 1)];
               foreach (p[i]) send(CMD_TEXT, p[i], 0);
            end else send(CMD_TEXT, 2'($urandom_range(0, 3)), 0);
            if ($urandom_range(0, 7) == 0) send(CMD_PATTERN, 2'($urandom_range(0, 3)), 1);
         end
         send(CMD_TEXT, 2'($urandom_range(0, 3)), 1);
      end

      stim_done = 1;
      wait_drain();
      $display("Sent %0d beats; checked %0d match beats and %0d closing beats.", sent,
               board.match_count, board.closes);
      if (board.errors == 0 && board.pending.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
`default_nettype wire

### files.f
src/tmpm_pkg.sv
src/tmpm_front.sv
src/tmpm_back.sv
src/trie_multi_pattern_matcher.sv
tb/sv/tb_top.sv
